[sv/ncc_pkg.sv]
// shared widths, constants and types for the correlation core
`timescale 1ns / 1ps
`default_nettype none
package ncc_pkg;

    localparam int COUNT_BITS = 22;
    localparam int PIXEL_BITS = 8;

    // frame counter holds 0 .. 2^COUNT_BITS
    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int SUM_W  = COUNT_BITS + PIXEL_BITS;
    localparam int SQ_W   = COUNT_BITS + 2 * PIXEL_BITS;
    localparam int PROD_W = CNT_W + SQ_W;
    localparam int VAR_W  = PROD_W;
    localparam int DEN_W  = 2 * VAR_W;

    // result in Q1.15, search runs over 0 .. 2^15
    localparam int VAL_W     = 16;
    localparam int Q_W       = VAL_W;
    localparam int K2_W      = 2 * Q_W;
    localparam int RHS_SHIFT = 2 * VAL_W;
    localparam int RHS_W     = DEN_W + RHS_SHIFT;

    localparam logic [Q_W-1:0]   Q_ONE = Q_W'(1 << (VAL_W - 1));
    localparam logic [VAL_W-1:0] Q_MAX = VAL_W'((1 << (VAL_W - 1)) - 1);

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sx;
        logic [SUM_W-1:0] sy;
        logic [SQ_W-1:0]  sxx;
        logic [SQ_W-1:0]  syy;
        logic [SQ_W-1:0]  sxy;
    } acc_sums_t;

endpackage
`default_nettype wire

[sv/normalized_cross_correlation_core.sv]
// Pearson correlation of two gray image streams, result per frame in Q1.15
//
// Input channel (in_valid/in_ready): one pixel pair per item, flagged in_roi
// when it belongs to the region and last_pixel on the final pixel of a frame.
// Ordinary pixels are taken at one per cycle while the sequencer is idle;
// every pixel counts into N, region pixels add into exact sums. The frame
// counter stops at 2^22 pixels. On a last pixel the input goes not ready
// while the end-of-frame sequencer runs a single shift-add multiplier (one
// multiplier bit per cycle): four variance products, two numerator products,
// the denominator and numerator squares, then a search of at most 16 steps
// for the rounded quotient with two products per step.
// Output channel (out_valid/out_ready): one item per frame, ncc_value in
// signed Q1.15 and status 1 for a flat image (value 0). The result sits in an
// output register, so pixels of the next frame keep flowing while it waits;
// a stalled receiver only holds off the end of the following frame.
// Reset clears the sums, the count and the output valid flag, not the output value.
`timescale 1ns / 1ps
`default_nettype none
module normalized_cross_correlation_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ncc_pkg::PIXEL_BITS-1:0] ref_pixel,
    input  logic [ncc_pkg::PIXEL_BITS-1:0] cmp_pixel,
    input  logic                           in_roi,
    input  logic                           last_pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [ncc_pkg::VAL_W-1:0] ncc_value,
    output logic                           status
);
    import ncc_pkg::*;

    acc_sums_t        sums;
    logic             accept;
    logic             seq_busy;
    logic             res_valid;
    logic [VAL_W-1:0] res_value;
    logic             res_status;
    logic             take;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [VAL_W-1:0] value_reg;
    logic             status_reg;

    assign in_ready = !seq_busy;
    assign accept   = in_valid && in_ready;
    // result moves on when the output register is empty or being emptied
    assign take     = res_valid && (!out_valid_reg || out_ready);

    ncc_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .clear (take),
        .x     (ref_pixel),
        .y     (cmp_pixel),
        .roi   (in_roi),
        .sums  (sums)
    );

    ncc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (accept && last_pixel),
        .take       (take),
        .sums       (sums),
        .busy       (seq_busy),
        .res_valid  (res_valid),
        .res_value  (res_value),
        .res_status (res_status)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg  <= res_value;
            status_reg <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign ncc_value = value_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

[sv/ncc_accum.sv]
// per-frame pixel count and region sums, one pixel pair per enabled cycle
`timescale 1ns / 1ps
`default_nettype none
module ncc_accum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           clear,
    input  logic [ncc_pkg::PIXEL_BITS-1:0] x,
    input  logic [ncc_pkg::PIXEL_BITS-1:0] y,
    input  logic                           roi,
    output ncc_pkg::acc_sums_t             sums
);
    import ncc_pkg::*;

    acc_sums_t sums_reg;
    acc_sums_t sums_next;
    logic [2*PIXEL_BITS-1:0] xx;
    logic [2*PIXEL_BITS-1:0] yy;
    logic [2*PIXEL_BITS-1:0] xy;

    assign xx = x * x;
    assign yy = y * y;
    assign xy = x * y;

    always_comb
    begin
        sums_next = sums_reg;
        if (clear)
        begin
            sums_next = '0;
        end
        // top bit of the count set means the frame limit is reached
        else if (en && !sums_reg.count[COUNT_BITS])
        begin
            sums_next.count = sums_reg.count + CNT_W'(1);
            if (roi)
            begin
                sums_next.sx  = sums_reg.sx + SUM_W'(x);
                sums_next.sy  = sums_reg.sy + SUM_W'(y);
                sums_next.sxx = sums_reg.sxx + SQ_W'(xx);
                sums_next.syy = sums_reg.syy + SQ_W'(yy);
                sums_next.sxy = sums_reg.sxy + SQ_W'(xy);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
        end
        else
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule
`default_nettype wire

[sv/ncc_mul.sv]
// shared shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ncc_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ncc_pkg::DEN_W-1:0] a,
    input  logic [ncc_pkg::VAR_W-1:0] b,
    output logic                      done,
    output logic [ncc_pkg::RHS_W-1:0] prod
);
    import ncc_pkg::*;

    logic             run_reg;
    logic             run_next;
    logic [RHS_W-1:0] a_reg;
    logic [RHS_W-1:0] a_next;
    logic [VAR_W-1:0] b_reg;
    logic [VAR_W-1:0] b_next;
    logic [RHS_W-1:0] acc_reg;
    logic [RHS_W-1:0] acc_next;

    // finished once no multiplier bits remain
    assign done = run_reg && (b_reg == '0);
    assign prod = acc_reg;

    always_comb
    begin
        run_next = run_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (start)
        begin
            run_next = 1'b1;
            a_next   = RHS_W'(a);
            b_next   = b;
            acc_next = '0;
        end
        else if (done)
        begin
            run_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next = {a_reg[RHS_W-2:0], 1'b0};
            b_next = {1'b0, b_reg[VAR_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule
`default_nettype wire

[sv/ncc_seq.sv]
// end-of-frame sequencer: variances, numerator and rounded quotient search
`timescale 1ns / 1ps
`default_nettype none
module ncc_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic                      take,
    input  ncc_pkg::acc_sums_t        sums,
    output logic                      busy,
    output logic                      res_valid,
    output logic [ncc_pkg::VAL_W-1:0] res_value,
    output logic                      res_status
);
    import ncc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_VX1   = 4'd2;
    localparam logic [3:0] S_VX2   = 4'd3;
    localparam logic [3:0] S_VY1   = 4'd4;
    localparam logic [3:0] S_VY2   = 4'd5;
    localparam logic [3:0] S_NUM1  = 4'd6;
    localparam logic [3:0] S_NUM2  = 4'd7;
    localparam logic [3:0] S_DEN   = 4'd8;
    localparam logic [3:0] S_RHS   = 4'd9;
    localparam logic [3:0] S_LOOP  = 4'd10;
    localparam logic [3:0] S_K2    = 4'd11;
    localparam logic [3:0] S_CMP   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [PROD_W-1:0] t1_reg;
    logic [PROD_W-1:0] t1_next;
    logic [VAR_W-1:0] vx_reg;
    logic [VAR_W-1:0] vx_next;
    logic [VAR_W-1:0] vy_reg;
    logic [VAR_W-1:0] vy_next;
    logic [VAR_W-1:0] num_reg;
    logic [VAR_W-1:0] num_next;
    logic             neg_reg;
    logic             neg_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [RHS_W-1:0] rhs_reg;
    logic [RHS_W-1:0] rhs_next;
    logic [Q_W-1:0]   lo_reg;
    logic [Q_W-1:0]   lo_next;
    logic [Q_W-1:0]   hi_reg;
    logic [Q_W-1:0]   hi_next;
    logic [Q_W-1:0]   mid_reg;
    logic [Q_W-1:0]   mid_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             status_reg;
    logic             status_next;

    logic             mul_start;
    logic [DEN_W-1:0] mul_a;
    logic [VAR_W-1:0] mul_b;
    logic             mul_done;
    logic [RHS_W-1:0] mul_prod;

    logic [PROD_W-1:0] prod_lo;
    logic              t1_gt;
    logic              t1_lt;
    logic [PROD_W-1:0] t1_minus;
    logic [PROD_W-1:0] minus_t1;
    logic [Q_W:0]      mid_sum;
    logic [Q_W-1:0]    mid_val;
    logic [Q_W:0]      k_dbl;
    logic [Q_W-1:0]    k_val;

    ncc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign prod_lo  = mul_prod[PROD_W-1:0];
    assign t1_gt    = t1_reg > prod_lo;
    assign t1_lt    = t1_reg < prod_lo;
    assign t1_minus = t1_reg - prod_lo;
    assign minus_t1 = prod_lo - t1_reg;

    // k = 2*mid - 1 with mid the upper middle of lo..hi
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + (Q_W + 1)'(1);
    assign mid_val = mid_sum[Q_W:1];
    assign k_dbl   = {mid_val, 1'b0} - (Q_W + 1)'(1);
    assign k_val   = k_dbl[Q_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        t1_next     = t1_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        num_next    = num_reg;
        neg_next    = neg_reg;
        den_next    = den_reg;
        rhs_next    = rhs_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        value_next  = value_reg;
        status_next = status_reg;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                mul_start  = 1'b1;
                mul_a      = DEN_W'(sums.sxx);
                mul_b      = VAR_W'(sums.count);
                state_next = S_VX1;
            end
            S_VX1:
            begin
                if (mul_done)
                begin
                    t1_next    = prod_lo;
                    mul_start  = 1'b1;
                    mul_a      = DEN_W'(sums.sx);
                    mul_b      = VAR_W'(sums.sx);
                    state_next = S_VX2;
                end
            end
            S_VX2:
            begin
                if (mul_done)
                begin
                    vx_next    = t1_gt ? t1_minus : '0;
                    mul_start  = 1'b1;
                    mul_a      = DEN_W'(sums.syy);
                    mul_b      = VAR_W'(sums.count);
                    state_next = S_VY1;
                end
            end
            S_VY1:
            begin
                if (mul_done)
                begin
                    t1_next    = prod_lo;
                    mul_start  = 1'b1;
                    mul_a      = DEN_W'(sums.sy);
                    mul_b      = VAR_W'(sums.sy);
                    state_next = S_VY2;
                end
            end
            S_VY2:
            begin
                if (mul_done)
                begin
                    vy_next = t1_gt ? t1_minus : '0;
                    // flat image on either side
                    if ((vx_reg == '0) || !t1_gt)
                    begin
                        value_next  = '0;
                        status_next = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = DEN_W'(sums.sxy);
                        mul_b      = VAR_W'(sums.count);
                        state_next = S_NUM1;
                    end
                end
            end
            S_NUM1:
            begin
                if (mul_done)
                begin
                    t1_next    = prod_lo;
                    mul_start  = 1'b1;
                    mul_a      = DEN_W'(sums.sx);
                    mul_b      = VAR_W'(sums.sy);
                    state_next = S_NUM2;
                end
            end
            S_NUM2:
            begin
                if (mul_done)
                begin
                    neg_next   = t1_lt;
                    num_next   = t1_lt ? minus_t1 : t1_minus;
                    mul_start  = 1'b1;
                    mul_a      = DEN_W'(vx_reg);
                    mul_b      = vy_reg;
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                if (mul_done)
                begin
                    den_next   = mul_prod[DEN_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = DEN_W'(num_reg);
                    mul_b      = num_reg;
                    state_next = S_RHS;
                end
            end
            S_RHS:
            begin
                if (mul_done)
                begin
                    rhs_next   = {mul_prod[DEN_W-1:0], {RHS_SHIFT{1'b0}}};
                    lo_next    = '0;
                    hi_next    = Q_ONE;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                // largest q with q == 0 or (2q-1)^2 * den <= num^2 * 2^32
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_val;
                    mul_start  = 1'b1;
                    mul_a      = DEN_W'(k_val);
                    mul_b      = VAR_W'(k_val);
                    state_next = S_K2;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_K2:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = den_reg;
                    mul_b      = VAR_W'(mul_prod[K2_W-1:0]);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (mul_done)
                begin
                    if (mul_prod <= rhs_reg)
                    begin
                        lo_next = mid_reg;
                    end
                    else
                    begin
                        hi_next = mid_reg - Q_W'(1);
                    end
                    state_next = S_LOOP;
                end
            end
            S_FIN:
            begin
                if (neg_reg)
                begin
                    value_next = ~lo_reg + VAL_W'(1);
                end
                else if (lo_reg[Q_W-1])
                begin
                    value_next = Q_MAX;
                end
                else
                begin
                    value_next = lo_reg;
                end
                status_next = 1'b0;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg     <= t1_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        num_reg    <= num_next;
        neg_reg    <= neg_next;
        den_reg    <= den_next;
        rhs_reg    <= rhs_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res_value  = value_reg;
    assign res_status = status_reg;

`ifndef ASSERT_OFF
    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == S_IDLE)
        else $error("frame end seen while sequencer busy");

    a_go_starts: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> state_reg == S_START)
        else $error("sequencer did not start after frame end");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> (hi_reg <= Q_ONE))
        else $error("search upper bound out of range");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !take) |=> (res_valid && $stable(res_value) && $stable(res_status)))
        else $error("pending result changed before it was taken");
`endif

endmodule
`default_nettype wire
